// File: hw/rtl/lsvf_pkg.sv
package lsvf_pkg;

  localparam int unsigned FRAC_BITS = 24;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 25;

  // one in q format less one lsb, and the band pass trim of 0.9
  localparam logic [DATA_W-1:0] ONE_Q  = DATA_W'((64'd1 << FRAC_BITS) - 64'd1);
  localparam logic [DATA_W-1:0] TRIM_Q = DATA_W'((64'hE66665 << FRAC_BITS) >> 24);

  localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DAMPING = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STEREO  = 3'd4;

  localparam logic [1:0] MODE_LOWPASS  = 2'd0;
  localparam logic [1:0] MODE_HIGHPASS = 2'd1;
  localparam logic [1:0] MODE_BANDPASS = 2'd2;
  localparam logic [1:0] MODE_BYPASS   = 2'd3;

  typedef enum logic [2:0] {
    A_X, A_DAMP, A_CUT, A_FB, A_ACC
  } a_sel_e;

  typedef enum logic [2:0] {
    B_CUT, B_IG, B_GAIN, B_BAND, B_LOW, B_TRIM
  } b_sel_e;

  typedef enum logic [2:0] {
    ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_SUB, ACC_DIFF
  } acc_op_e;

  typedef enum logic [1:0] {
    RES_NONE, RES_LOW, RES_HIGH, RES_PROD
  } res_sel_e;

  typedef struct packed {
    a_sel_e   a_sel;
    b_sel_e   b_sel;
    acc_op_e  acc_op;
    logic     wr_fb;
    logic     wr_gain;
    logic     wr_band;
    logic     wr_low;
    res_sel_e res_sel;
    logic     ch;
    logic     capture;
    logic     out_load;
  } lsvf_cmd_t;

endpackage

// File: hw/rtl/lsvf_datapath.sv
module lsvf_datapath import lsvf_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lsvf_cmd_t             cmd_i,
  input  logic [23:0]           cutoff_i,
  input  logic [23:0]           damping_i,
  input  logic [24:0]           gain_i,
  input  logic [2*DATA_W-1:0]   in_data_i,
  output logic [2*DATA_W-1:0]   out_data_o
);

  logic signed [DATA_W-1:0]   op_a, op_b;
  logic signed [2*DATA_W-1:0] prod_q;
  logic [DATA_W-1:0] q;
  logic [DATA_W-1:0] acc_d, acc_q;
  logic [DATA_W-1:0] fb_q, gain_q;
  logic [DATA_W-1:0] x_l_q, x_r_q, x_cur;
  logic [DATA_W-1:0] band_l_q, band_r_q, low_l_q, low_r_q;
  logic [DATA_W-1:0] band_cur, low_cur;
  logic [DATA_W-1:0] res_l_q, res_r_q, res_val;
  logic [2*DATA_W-1:0] out_q;

  // scaled product, wrapped to the word width
  assign q = prod_q[FRAC_BITS +: DATA_W];

  assign x_cur    = cmd_i.ch ? x_r_q    : x_l_q;
  assign band_cur = cmd_i.ch ? band_r_q : band_l_q;
  assign low_cur  = cmd_i.ch ? low_r_q  : low_l_q;

  always_comb begin
    unique case (cmd_i.a_sel)
      A_X:     op_a = x_cur;
      A_DAMP:  op_a = {8'd0, damping_i};
      A_CUT:   op_a = {8'd0, cutoff_i};
      A_FB:    op_a = fb_q;
      A_ACC:   op_a = acc_q;
      default: op_a = x_cur;
    endcase
  end

  always_comb begin
    unique case (cmd_i.b_sel)
      B_CUT:   op_b = {8'd0, cutoff_i};
      B_IG:    op_b = {7'd0, gain_i};
      B_GAIN:  op_b = gain_q;
      B_BAND:  op_b = band_cur;
      B_LOW:   op_b = low_cur;
      B_TRIM:  op_b = TRIM_Q;
      default: op_b = gain_q;
    endcase
  end

  always_comb begin
    unique case (cmd_i.acc_op)
      ACC_HOLD: acc_d = acc_q;
      ACC_LOAD: acc_d = q;
      ACC_ADD:  acc_d = acc_q + q;
      ACC_SUB:  acc_d = acc_q - q;
      ACC_DIFF: acc_d = band_cur - low_cur;
      default:  acc_d = acc_q;
    endcase
  end

  always_comb begin
    unique case (cmd_i.res_sel)
      RES_LOW:  res_val = low_cur;
      RES_HIGH: res_val = x_cur - low_cur;
      RES_PROD: res_val = q;
      default:  res_val = low_cur;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= op_a * op_b;
    acc_q  <= acc_d;
    if (cmd_i.wr_fb) begin
      fb_q <= ONE_Q - q;
    end
    if (cmd_i.wr_gain) begin
      gain_q <= q;
    end
    if (cmd_i.capture) begin
      x_l_q   <= in_data_i[DATA_W-1:0];
      x_r_q   <= in_data_i[2*DATA_W-1:DATA_W];
      res_l_q <= in_data_i[DATA_W-1:0];
      res_r_q <= in_data_i[2*DATA_W-1:DATA_W];
    end else if (cmd_i.res_sel != RES_NONE) begin
      if (cmd_i.ch) begin
        res_r_q <= res_val;
      end else begin
        res_l_q <= res_val;
      end
    end
    if (cmd_i.out_load) begin
      out_q <= {res_r_q, res_l_q};
    end
  end

  // integrator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      band_l_q <= '0;
      band_r_q <= '0;
      low_l_q  <= '0;
      low_r_q  <= '0;
    end else begin
      if (cmd_i.wr_band) begin
        if (cmd_i.ch) begin
          band_r_q <= acc_d;
        end else begin
          band_l_q <= acc_d;
        end
      end
      if (cmd_i.wr_low) begin
        if (cmd_i.ch) begin
          low_r_q <= acc_d;
        end else begin
          low_l_q <= acc_d;
        end
      end
    end
  end

  assign out_data_o = out_q;

endmodule

// File: hw/rtl/lsvf_ctrl.sv
module lsvf_ctrl import lsvf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  logic [1:0] mode_i,
  input  logic      stereo_i,
  output lsvf_cmd_t cmd_o
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_FB    = 4'd1;
  localparam logic [3:0] ST_GAIN  = 4'd2;
  localparam logic [3:0] ST_STORE = 4'd3;
  localparam logic [3:0] ST_C1    = 4'd4;
  localparam logic [3:0] ST_C2    = 4'd5;
  localparam logic [3:0] ST_C3    = 4'd6;
  localparam logic [3:0] ST_C4    = 4'd7;
  localparam logic [3:0] ST_C5    = 4'd8;
  localparam logic [3:0] ST_C6    = 4'd9;
  localparam logic [3:0] ST_C7    = 4'd10;
  localparam logic [3:0] ST_C8    = 4'd11;
  localparam logic [3:0] ST_C9    = 4'd12;
  localparam logic [3:0] ST_FIN   = 4'd13;

  logic [3:0] state_d, state_q;
  logic       ch_d, ch_q;
  logic       out_valid_d, out_valid_q;
  logic       in_accept, out_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_accept   = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    ch_d        = ch_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    cmd_o.ch    = ch_q;
    unique case (state_q)
      ST_IDLE: begin
        ch_d = 1'b0;
        if (in_accept) begin
          cmd_o.capture = 1'b1;
          state_d = (mode_i == MODE_BYPASS) ? ST_FIN : ST_FB;
        end
      end
      ST_FB: begin
        cmd_o.a_sel = A_DAMP;
        cmd_o.b_sel = B_CUT;
        state_d = ST_GAIN;
      end
      ST_GAIN: begin
        cmd_o.a_sel = A_CUT;
        cmd_o.b_sel = B_IG;
        cmd_o.wr_fb = 1'b1;
        state_d = ST_STORE;
      end
      ST_STORE: begin
        cmd_o.wr_gain = 1'b1;
        state_d = ST_C1;
      end
      ST_C1: begin
        cmd_o.a_sel = A_X;
        cmd_o.b_sel = B_GAIN;
        state_d = ST_C2;
      end
      ST_C2: begin
        cmd_o.a_sel  = A_FB;
        cmd_o.b_sel  = B_BAND;
        cmd_o.acc_op = ACC_LOAD;
        state_d = ST_C3;
      end
      ST_C3: begin
        cmd_o.a_sel  = A_CUT;
        cmd_o.b_sel  = B_LOW;
        cmd_o.acc_op = ACC_ADD;
        state_d = ST_C4;
      end
      ST_C4: begin
        // low product is taken here, before the band update lands
        cmd_o.a_sel   = A_FB;
        cmd_o.b_sel   = B_LOW;
        cmd_o.acc_op  = ACC_SUB;
        cmd_o.wr_band = 1'b1;
        state_d = ST_C5;
      end
      ST_C5: begin
        cmd_o.a_sel  = A_CUT;
        cmd_o.b_sel  = B_BAND;
        cmd_o.acc_op = ACC_LOAD;
        state_d = ST_C6;
      end
      ST_C6: begin
        cmd_o.acc_op = ACC_ADD;
        cmd_o.wr_low = 1'b1;
        state_d = ST_C7;
      end
      ST_C7: begin
        cmd_o.acc_op  = ACC_DIFF;
        cmd_o.res_sel = (mode_i == MODE_HIGHPASS) ? RES_HIGH : RES_LOW;
        if (mode_i == MODE_BANDPASS) begin
          state_d = ST_C8;
        end else if (!ch_q && stereo_i) begin
          ch_d    = 1'b1;
          state_d = ST_C1;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_C8: begin
        cmd_o.a_sel = A_ACC;
        cmd_o.b_sel = B_TRIM;
        state_d = ST_C9;
      end
      ST_C9: begin
        cmd_o.res_sel = RES_PROD;
        if (!ch_q && stereo_i) begin
          ch_d    = 1'b1;
          state_d = ST_C1;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ch_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ch_q        <= ch_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef SYNTHESIS
  a_load_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over an unread word");

  a_bypass_skips: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && mode_i == MODE_BYPASS) |=> (state_q == ST_FIN))
    else $error("bypass word went through the filter sequence");

  a_right_only_stereo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ch_q && state_q != ST_IDLE) |-> stereo_i)
    else $error("right channel filtered in mono");

  a_valid_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_FIN))
    else $error("result valid raised outside the finish step");
`endif

endmodule

// File: hw/rtl/leaky_state_variable_filter_q24_top.sv
// Leaky state-variable filter on Q24 audio, one stereo frame per input word. A single
// shared 32x32 multiplier sequenced by a small controller sets the timing: an input word
// is taken only while the block is idle, and m_axis_tvalid rises after the controller has
// run the filter steps on each filtered channel (both in stereo), plus the trim steps in
// band pass; bypass goes straight to the finish step. One finished word waits in an output
// register, so the next input is taken while the previous result is still unread. Config
// writes are always accepted and must only be made while no word is in flight.
module leaky_state_variable_filter_q24_top import lsvf_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [2*DATA_W-1:0]      s_axis_tdata,  // right_sample (upper), left_sample (lower)
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [2*DATA_W-1:0]      m_axis_tdata,  // right_result (upper), left_result (lower)
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [CFG_DAT_W-1:0]     cfg_data_i
);

  logic [23:0] cutoff_q, damping_q;
  logic [24:0] gain_q;
  logic [1:0]  mode_q;
  logic        stereo_q;
  lsvf_cmd_t   cmd;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cutoff_q  <= '0;
      damping_q <= '0;
      gain_q    <= 25'd16777215;
      mode_q    <= MODE_LOWPASS;
      stereo_q  <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_CUTOFF:  cutoff_q  <= cfg_data_i[23:0];
        CFG_DAMPING: damping_q <= cfg_data_i[23:0];
        CFG_GAIN:    gain_q    <= cfg_data_i;
        CFG_MODE:    mode_q    <= cfg_data_i[1:0];
        CFG_STEREO:  stereo_q  <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  lsvf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .mode_i      (mode_q),
    .stereo_i    (stereo_q),
    .cmd_o       (cmd)
  );

  lsvf_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .cutoff_i   (cutoff_q),
    .damping_i  (damping_q),
    .gain_i     (gain_q),
    .in_data_i  (s_axis_tdata),
    .out_data_o (m_axis_tdata)
  );

endmodule
